// ===== src/lmfsc_pkg.sv =====
// Shared constants for the low Mach face state correction block.
`timescale 1ns / 1ps

package lmfsc_pkg;

    // Default width of one packed velocity or area component.
    localparam int COMPONENT_BITS_DEF = 21;

    // Fixed field widths.
    localparam int RHO_W = 32;
    localparam int GAM_W = 15;
    localparam int PRS_W = 32;
    localparam int VEC_W = 63;
    localparam int GP_W  = RHO_W + GAM_W;

    // Input word layout, lowest field first.
    localparam int IN_RHO_L = 0;
    localparam int IN_RHO_R = IN_RHO_L + RHO_W;
    localparam int IN_GAM_L = IN_RHO_R + RHO_W;
    localparam int IN_GAM_R = IN_GAM_L + GAM_W;
    localparam int IN_PRS_L = IN_GAM_R + GAM_W;
    localparam int IN_PRS_R = IN_PRS_L + PRS_W;
    localparam int IN_VEL_L = IN_PRS_R + PRS_W;
    localparam int IN_VEL_R = IN_VEL_L + VEC_W;
    localparam int IN_AREA  = IN_VEL_R + VEC_W;
    localparam int IN_USED  = IN_AREA + VEC_W;
    localparam int IN_W     = ((IN_USED + 7) / 8) * 8;

    // Output word layout, lowest field first.
    localparam int OUT_VEL_L = 0;
    localparam int OUT_VEL_R = OUT_VEL_L + VEC_W;
    localparam int OUT_PRS_L = OUT_VEL_R + VEC_W;
    localparam int OUT_PRS_R = OUT_PRS_L + PRS_W;
    localparam int OUT_USED  = OUT_PRS_R + PRS_W;
    localparam int OUT_W     = ((OUT_USED + 7) / 8) * 8;
    localparam int USER_W    = 2;
    localparam int USER_CORR = 0;
    localparam int USER_CLMP = 1;

    // Arithmetic constants.
    localparam logic [GAM_W-1:0] GAMMA_ONE = 15'd16384;
    localparam int               MACH_Q    = 17;
    localparam logic [MACH_Q-1:0] MACH_ONE = 17'd65536;
    localparam logic [PRS_W-1:0] P_MAX     = 32'hFFFF_FFFF;
    localparam int               C2_Q      = 63;
    localparam int               ROOT_N    = 64;
    localparam int               C2_SHIFT  = 16;
    localparam int               DOT_SHIFT = 14;
    localparam int               RND_POS   = 48;

endpackage

// ===== src/lmfsc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module lmfsc_div #(
    parameter int D = 32,
    parameter int Q = 63
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [D-1:0] i_rem,
    input  logic [Q-1:0] i_low,
    input  logic [D-1:0] i_div,
    output logic [Q-1:0] o_quo
);

    logic [D-1:0] r_rem  [Q];
    logic [Q-1:0] r_word [Q];
    logic [D-1:0] r_div  [Q];

    for (genvar k = 0; k < Q; k++) begin : g_stage
        logic [D-1:0] rem_in;
        logic [Q-1:0] word_in;
        logic [D-1:0] div_in;
        logic [D:0]   trial;
        logic         ge;
        logic [D-1:0] n_rem;

        if (k == 0) begin : g_first
            assign rem_in  = i_rem;
            assign word_in = i_low;
            assign div_in  = i_div;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign word_in = r_word[k-1];
            assign div_in  = r_div[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign trial = {rem_in, word_in[Q-1]};
        assign ge    = trial >= {1'b0, div_in};
        assign n_rem = ge ? D'(trial - {1'b0, div_in}) : trial[D-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_word[k] <= {word_in[Q-2:0], ge};
                r_div[k]  <= div_in;
            end
        end
    end

    assign o_quo = r_word[Q-1];

endmodule

// ===== src/lmfsc_sqrt.sv =====
// Pipelined floor square root, one root bit per stage.
`timescale 1ns / 1ps

module lmfsc_sqrt #(
    parameter int N = 64
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [N-1:0]   i_val,
    output logic [N/2-1:0] o_root
);

    localparam int R = N / 2;

    logic [R+1:0] r_rem  [R];
    logic [R-1:0] r_root [R];
    logic [N-1:0] r_word [R];

    for (genvar k = 0; k < R; k++) begin : g_stage
        logic [R+1:0] rem_in;
        logic [R-1:0] root_in;
        logic [N-1:0] word_in;
        logic [R+1:0] t;
        logic [R+1:0] trial;
        logic         ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign word_in = i_val;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign word_in = r_word[k-1];
        end

        // bring down the next bit pair, try root*4+1
        assign t     = {rem_in[R-1:0], word_in[N-1:N-2]};
        assign trial = {root_in, 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (t - trial) : t;
                r_root[k] <= {root_in[R-2:0], ge};
                r_word[k] <= {word_in[N-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[R-1];

endmodule

// ===== src/low_mach_face_state_correction.sv =====
// Top level: low Mach face state correction, one face per cycle while the output is not stalled.
`timescale 1ns / 1ps
// Stages from an accepted input word to its result word: 3 front stages, 63 sound speed
// divide stages, 32 square root stages, 2 setup stages, 17 Mach divide stages and 8 blend
// and pressure stages including the output register.
// Throughput: one word per cycle; the whole pipe advances whenever the output register
// is empty or being taken, so a stall holds every stage in place.
// Reset: synchronous active low i_rst_n clears all valid bits; payload is not reset.

module low_mach_face_state_correction #(
    parameter int COMPONENT_BITS = lmfsc_pkg::COMPONENT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave side
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // tdata, lowest bit up: density_left, density_right, heat_ratio_left,
    // heat_ratio_right, pressure_left, pressure_right, velocity_left,
    // velocity_right, face_area, zero fill
    input  logic [lmfsc_pkg::IN_W-1:0]   i_s_tdata,
    // master side
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // tdata, lowest bit up: velocity_left_out, velocity_right_out,
    // pressure_left_out, pressure_right_out, zero fill
    output logic [lmfsc_pkg::OUT_W-1:0]  o_m_tdata,
    // tuser, lowest bit up: corrected, pressure_clamped
    output logic [lmfsc_pkg::USER_W-1:0] o_m_tuser
);

    localparam int C     = COMPONENT_BITS;
    localparam int VW    = 3 * C;
    localparam int PW    = 2 * C;           // one product of two components
    localparam int SW    = 2 * C + 2;       // sum of three products
    localparam int NUMW  = SW + lmfsc_pkg::DOT_SHIFT;
    localparam int DENW  = C + 32;
    localparam int CMPW  = NUMW + DENW;
    localparam int PB    = C + 19;          // blend weight times component
    localparam int H     = SW / 2;
    localparam int GW    = lmfsc_pkg::GP_W;
    localparam int PRW   = GW + SW;
    localparam int TW    = PRW - 49;
    localparam int SUMW  = TW + 33;
    localparam int RW    = lmfsc_pkg::ROOT_N / 2;
    localparam int MQ    = lmfsc_pkg::MACH_Q;

    // One item as it travels down the pipe; each stage fills in its fields.
    typedef struct packed {
        logic                       vld;
        logic [31:0]                rho_l, rho_r, p_l, p_r;
        logic [14:0]                gam_l, gam_r;
        logic [VW-1:0]              vl, vr, area;
        logic [2:0][PW-1:0]         pa, pdl, pdr, pol, por;
        logic [GW-1:0]              gp_l, gp_r, rg_l, rg_r;
        logic                       gneg_l, gneg_r;
        logic [SW-1:0]              a2, adl, adr, ol2, or2;
        logic                       pass;
        logic [DENW-1:0]            den_l, den_r;
        logic [NUMW-1:0]            num_l, num_r;
        logic                       over_l, over_r;
        logic [MQ-1:0]              z;
        logic [2:0][PB-1:0]         bla, blb, bra, brb;
        logic [VW-1:0]              nl, nr;
        logic [2:0][PW-1:0]         sql, sqr;
        logic [SW-1:0]              dabs_l, dabs_r;
        logic                       neg_l, neg_r;
        logic [GW+H-1:0]            ppl_lo, ppl_hi, ppr_lo, ppr_hi;
        logic [TW-1:0]              term_l, term_r;
    } t_item;

    typedef struct packed {
        logic                       vld;
        logic [VW-1:0]              vl, vr;
        logic [31:0]                pl, pr;
        logic                       corr, clmp;
    } t_out;

    function automatic logic signed [C-1:0] f_comp(input logic [VW-1:0] v, input int k);
        return v[k*C +: C];
    endfunction

    function automatic logic signed [SW-1:0] f_sx(input logic [PW-1:0] x);
        return {{2{x[PW-1]}}, x};
    endfunction

    function automatic logic [MQ-1:0] f_mach(input logic dz, input logic nz,
                                             input logic over, input logic [MQ-1:0] q);
        if (dz) return nz ? lmfsc_pkg::MACH_ONE : '0;
        if (over || q > lmfsc_pkg::MACH_ONE) return lmfsc_pkg::MACH_ONE;
        return q;
    endfunction

    logic en;
    t_item n_s1, r_s1, n_s2, r_s2, n_s3, r_s3;
    t_item r_da [lmfsc_pkg::C2_Q];
    t_item r_db [RW];
    t_item n_m, r_m, n_m2, r_m2;
    t_item r_dc [MQ];
    t_item n_z, r_z, n_b1, r_b1, n_b2, r_b2, n_q, r_q, n_d, r_d;
    t_item n_p1, r_p1, n_p2, r_p2;
    t_out  n_out, r_out;

    logic [lmfsc_pkg::C2_Q-1:0] c2_l, c2_r;
    logic [RW-1:0]              c_l, c_r, root_a;
    logic [MQ-1:0]              q_l, q_r;

    // Advance the whole pipe when the output register is free or being taken.
    assign en         = !r_out.vld || i_m_tready;
    assign o_s_tready = en;

    // Stage 1: capture the input word, drop packed bits above the components.
    always_comb begin
        n_s1       = '0;
        n_s1.vld   = i_s_tvalid;
        n_s1.rho_l = i_s_tdata[lmfsc_pkg::IN_RHO_L +: 32];
        n_s1.rho_r = i_s_tdata[lmfsc_pkg::IN_RHO_R +: 32];
        n_s1.gam_l = i_s_tdata[lmfsc_pkg::IN_GAM_L +: 15];
        n_s1.gam_r = i_s_tdata[lmfsc_pkg::IN_GAM_R +: 15];
        n_s1.p_l   = i_s_tdata[lmfsc_pkg::IN_PRS_L +: 32];
        n_s1.p_r   = i_s_tdata[lmfsc_pkg::IN_PRS_R +: 32];
        n_s1.vl    = i_s_tdata[lmfsc_pkg::IN_VEL_L +: VW];
        n_s1.vr    = i_s_tdata[lmfsc_pkg::IN_VEL_R +: VW];
        n_s1.area  = i_s_tdata[lmfsc_pkg::IN_AREA +: VW];
    end

    // Stage 2: all component products, gamma*p and rho*|gamma-1|.
    always_comb begin
        logic [14:0] gabs_l, gabs_r;
        n_s2        = r_s1;
        for (int k = 0; k < 3; k++) begin
            n_s2.pa[k]  = f_comp(r_s1.area, k) * f_comp(r_s1.area, k);
            n_s2.pdl[k] = f_comp(r_s1.vl, k) * f_comp(r_s1.area, k);
            n_s2.pdr[k] = f_comp(r_s1.vr, k) * f_comp(r_s1.area, k);
            n_s2.pol[k] = f_comp(r_s1.vl, k) * f_comp(r_s1.vl, k);
            n_s2.por[k] = f_comp(r_s1.vr, k) * f_comp(r_s1.vr, k);
        end
        n_s2.gneg_l = r_s1.gam_l < lmfsc_pkg::GAMMA_ONE;
        n_s2.gneg_r = r_s1.gam_r < lmfsc_pkg::GAMMA_ONE;
        gabs_l = n_s2.gneg_l ? (lmfsc_pkg::GAMMA_ONE - r_s1.gam_l)
                             : (r_s1.gam_l - lmfsc_pkg::GAMMA_ONE);
        gabs_r = n_s2.gneg_r ? (lmfsc_pkg::GAMMA_ONE - r_s1.gam_r)
                             : (r_s1.gam_r - lmfsc_pkg::GAMMA_ONE);
        n_s2.gp_l = GW'(r_s1.gam_l) * GW'(r_s1.p_l);
        n_s2.gp_r = GW'(r_s1.gam_r) * GW'(r_s1.p_r);
        n_s2.rg_l = GW'(r_s1.rho_l) * GW'(gabs_l);
        n_s2.rg_r = GW'(r_s1.rho_r) * GW'(gabs_r);
    end

    // Stage 3: dot products and squared norms, pass-through on zero inputs.
    always_comb begin
        logic signed [SW-1:0] sdl, sdr;
        n_s3     = r_s2;
        n_s3.a2  = SW'(r_s2.pa[0]) + SW'(r_s2.pa[1]) + SW'(r_s2.pa[2]);
        n_s3.ol2 = SW'(r_s2.pol[0]) + SW'(r_s2.pol[1]) + SW'(r_s2.pol[2]);
        n_s3.or2 = SW'(r_s2.por[0]) + SW'(r_s2.por[1]) + SW'(r_s2.por[2]);
        sdl      = f_sx(r_s2.pdl[0]) + f_sx(r_s2.pdl[1]) + f_sx(r_s2.pdl[2]);
        sdr      = f_sx(r_s2.pdr[0]) + f_sx(r_s2.pdr[1]) + f_sx(r_s2.pdr[2]);
        n_s3.adl = sdl[SW-1] ? SW'(-sdl) : SW'(sdl);
        n_s3.adr = sdr[SW-1] ? SW'(-sdr) : SW'(sdr);
        n_s3.pass = (r_s2.rho_l == '0) || (r_s2.rho_r == '0) || (r_s2.p_l == '0) ||
                    (r_s2.p_r == '0) || (n_s3.a2 == '0);
    end

    // Sound speed squared: gamma*p*2^16 / rho, full quotient.
    lmfsc_div #(.D(32), .Q(lmfsc_pkg::C2_Q)) u_div_c2_l (
        .i_clk (i_clk), .i_en (en), .i_rem ('0),
        .i_low ({r_s3.gp_l, {lmfsc_pkg::C2_SHIFT{1'b0}}}),
        .i_div (r_s3.rho_l), .o_quo (c2_l)
    );
    lmfsc_div #(.D(32), .Q(lmfsc_pkg::C2_Q)) u_div_c2_r (
        .i_clk (i_clk), .i_en (en), .i_rem ('0),
        .i_low ({r_s3.gp_r, {lmfsc_pkg::C2_SHIFT{1'b0}}}),
        .i_div (r_s3.rho_r), .o_quo (c2_r)
    );

    // Sound speeds and face vector length, all three in one root segment.
    lmfsc_sqrt #(.N(lmfsc_pkg::ROOT_N)) u_sqrt_c_l (
        .i_clk (i_clk), .i_en (en), .i_val ({1'b0, c2_l}), .o_root (c_l)
    );
    lmfsc_sqrt #(.N(lmfsc_pkg::ROOT_N)) u_sqrt_c_r (
        .i_clk (i_clk), .i_en (en), .i_val ({1'b0, c2_r}), .o_root (c_r)
    );
    lmfsc_sqrt #(.N(lmfsc_pkg::ROOT_N)) u_sqrt_a (
        .i_clk (i_clk), .i_en (en), .i_val (lmfsc_pkg::ROOT_N'(r_da[lmfsc_pkg::C2_Q-1].a2)),
        .o_root (root_a)
    );

    // Stage M: Mach denominators |A|*c and numerators |v.A|*2^14.
    always_comb begin
        n_m       = r_db[RW-1];
        n_m.den_l = DENW'(root_a[C-1:0]) * DENW'(c_l);
        n_m.den_r = DENW'(root_a[C-1:0]) * DENW'(c_r);
        n_m.num_l = {r_db[RW-1].adl, {lmfsc_pkg::DOT_SHIFT{1'b0}}};
        n_m.num_r = {r_db[RW-1].adr, {lmfsc_pkg::DOT_SHIFT{1'b0}}};
    end

    // Stage M2: flag quotients that reach 2^17, which saturate anyway.
    always_comb begin
        n_m2        = r_m;
        n_m2.over_l = CMPW'(r_m.num_l[NUMW-1:MQ]) >= CMPW'(r_m.den_l);
        n_m2.over_r = CMPW'(r_m.num_r[NUMW-1:MQ]) >= CMPW'(r_m.den_r);
    end

    lmfsc_div #(.D(DENW), .Q(MQ)) u_div_m_l (
        .i_clk (i_clk), .i_en (en), .i_rem (DENW'(r_m2.num_l[NUMW-1:MQ])),
        .i_low (r_m2.num_l[MQ-1:0]), .i_div (r_m2.den_l), .o_quo (q_l)
    );
    lmfsc_div #(.D(DENW), .Q(MQ)) u_div_m_r (
        .i_clk (i_clk), .i_en (en), .i_rem (DENW'(r_m2.num_r[NUMW-1:MQ])),
        .i_low (r_m2.num_r[MQ-1:0]), .i_div (r_m2.den_r), .o_quo (q_r)
    );

    // Stage Z: cap each Mach number, take the larger, decide pass-through.
    always_comb begin
        logic [MQ-1:0] ml, mr;
        n_z = r_dc[MQ-1];
        ml  = f_mach(r_dc[MQ-1].den_l == '0, r_dc[MQ-1].num_l != '0,
                     r_dc[MQ-1].over_l, q_l);
        mr  = f_mach(r_dc[MQ-1].den_r == '0, r_dc[MQ-1].num_r != '0,
                     r_dc[MQ-1].over_r, q_r);
        n_z.z    = (ml > mr) ? ml : mr;
        n_z.pass = r_dc[MQ-1].pass || (n_z.z == '0) || (n_z.z == lmfsc_pkg::MACH_ONE);
    end

    // Stage B1: weighted components, (1+z) on own side and (1-z) on the other.
    always_comb begin
        logic signed [MQ+1:0] wp, wm;
        n_b1 = r_z;
        wp   = $signed({1'b0, 1'b0, r_z.z}) + $signed({1'b0, lmfsc_pkg::MACH_ONE});
        wm   = $signed({1'b0, lmfsc_pkg::MACH_ONE}) - $signed({1'b0, 1'b0, r_z.z});
        for (int k = 0; k < 3; k++) begin
            n_b1.bla[k] = wp * f_comp(r_z.vl, k);
            n_b1.blb[k] = wm * f_comp(r_z.vr, k);
            n_b1.bra[k] = wp * f_comp(r_z.vr, k);
            n_b1.brb[k] = wm * f_comp(r_z.vl, k);
        end
    end

    // Stage B2: sum and round to nearest, ties away from zero.
    always_comb begin
        logic signed [PB:0] sl, sr;
        logic [PB+1:0]      ml, mr, ql, qr;
        n_b2 = r_b1;
        for (int k = 0; k < 3; k++) begin
            sl = {r_b1.bla[k][PB-1], r_b1.bla[k]} + {r_b1.blb[k][PB-1], r_b1.blb[k]};
            sr = {r_b1.bra[k][PB-1], r_b1.bra[k]} + {r_b1.brb[k][PB-1], r_b1.brb[k]};
            ml = sl[PB] ? (PB+2)'(-sl) : (PB+2)'(sl);
            mr = sr[PB] ? (PB+2)'(-sr) : (PB+2)'(sr);
            ql = (ml + (PB+2)'(lmfsc_pkg::MACH_ONE)) >> MQ;
            qr = (mr + (PB+2)'(lmfsc_pkg::MACH_ONE)) >> MQ;
            n_b2.nl[k*C +: C] = sl[PB] ? C'(-ql) : ql[C-1:0];
            n_b2.nr[k*C +: C] = sr[PB] ? C'(-qr) : qr[C-1:0];
        end
    end

    // Stage Q: squares of the blended components.
    always_comb begin
        n_q = r_b2;
        for (int k = 0; k < 3; k++) begin
            n_q.sql[k] = f_comp(r_b2.nl, k) * f_comp(r_b2.nl, k);
            n_q.sqr[k] = f_comp(r_b2.nr, k) * f_comp(r_b2.nr, k);
        end
    end

    // Stage D: kinetic change |v|^2 - |v'|^2 and the sign of the pressure step.
    always_comb begin
        logic [SW-1:0]      nl2, nr2;
        logic signed [SW:0] dl, dr;
        n_d = r_q;
        nl2 = SW'(r_q.sql[0]) + SW'(r_q.sql[1]) + SW'(r_q.sql[2]);
        nr2 = SW'(r_q.sqr[0]) + SW'(r_q.sqr[1]) + SW'(r_q.sqr[2]);
        dl  = $signed({1'b0, r_q.ol2}) - $signed({1'b0, nl2});
        dr  = $signed({1'b0, r_q.or2}) - $signed({1'b0, nr2});
        n_d.dabs_l = dl[SW] ? SW'(-dl) : dl[SW-1:0];
        n_d.dabs_r = dr[SW] ? SW'(-dr) : dr[SW-1:0];
        n_d.neg_l  = r_q.gneg_l != dl[SW];
        n_d.neg_r  = r_q.gneg_r != dr[SW];
    end

    // Stage P1: rho*|gamma-1| times |d|, split in two partial products.
    always_comb begin
        n_p1        = r_d;
        n_p1.ppl_lo = (GW+H)'(r_d.rg_l) * (GW+H)'(r_d.dabs_l[H-1:0]);
        n_p1.ppl_hi = (GW+H)'(r_d.rg_l) * (GW+H)'(r_d.dabs_l[SW-1:H]);
        n_p1.ppr_lo = (GW+H)'(r_d.rg_r) * (GW+H)'(r_d.dabs_r[H-1:0]);
        n_p1.ppr_hi = (GW+H)'(r_d.rg_r) * (GW+H)'(r_d.dabs_r[SW-1:H]);
    end

    // Stage P2: combine and round the pressure step to 8 fraction bits.
    always_comb begin
        logic [PRW-1:0] prl, prr;
        n_p2 = r_p1;
        prl  = PRW'(r_p1.ppl_lo) + (PRW'(r_p1.ppl_hi) << H);
        prr  = PRW'(r_p1.ppr_lo) + (PRW'(r_p1.ppr_hi) << H);
        n_p2.term_l = TW'((prl + (PRW'(1) << lmfsc_pkg::RND_POS)) >> 49);
        n_p2.term_r = TW'((prr + (PRW'(1) << lmfsc_pkg::RND_POS)) >> 49);
    end

    // Output stage: apply the step, clamp at zero or saturate high.
    always_comb begin
        logic [SUMW-1:0] sl, sr;
        logic            cl, cr;
        logic [31:0]     pl, pr;
        sl = SUMW'(r_p2.p_l) + SUMW'(r_p2.term_l);
        sr = SUMW'(r_p2.p_r) + SUMW'(r_p2.term_r);
        cl = r_p2.neg_l && (SUMW'(r_p2.term_l) > SUMW'(r_p2.p_l));
        cr = r_p2.neg_r && (SUMW'(r_p2.term_r) > SUMW'(r_p2.p_r));
        if (r_p2.neg_l) begin
            pl = cl ? '0 : 32'(SUMW'(r_p2.p_l) - SUMW'(r_p2.term_l));
        end else begin
            pl = (sl > SUMW'(lmfsc_pkg::P_MAX)) ? lmfsc_pkg::P_MAX : sl[31:0];
        end
        if (r_p2.neg_r) begin
            pr = cr ? '0 : 32'(SUMW'(r_p2.p_r) - SUMW'(r_p2.term_r));
        end else begin
            pr = (sr > SUMW'(lmfsc_pkg::P_MAX)) ? lmfsc_pkg::P_MAX : sr[31:0];
        end
        n_out.vld = r_p2.vld;
        if (r_p2.pass) begin
            n_out.vl   = r_p2.vl;
            n_out.vr   = r_p2.vr;
            n_out.pl   = r_p2.p_l;
            n_out.pr   = r_p2.p_r;
            n_out.corr = 1'b0;
            n_out.clmp = 1'b0;
        end else begin
            n_out.vl   = r_p2.nl;
            n_out.vr   = r_p2.nr;
            n_out.pl   = pl;
            n_out.pr   = pr;
            n_out.corr = 1'b1;
            n_out.clmp = cl || cr;
        end
    end

    // Plain stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld  <= 1'b0;
            r_s2.vld  <= 1'b0;
            r_s3.vld  <= 1'b0;
            r_m.vld   <= 1'b0;
            r_m2.vld  <= 1'b0;
            r_z.vld   <= 1'b0;
            r_b1.vld  <= 1'b0;
            r_b2.vld  <= 1'b0;
            r_q.vld   <= 1'b0;
            r_d.vld   <= 1'b0;
            r_p1.vld  <= 1'b0;
            r_p2.vld  <= 1'b0;
            r_out.vld <= 1'b0;
        end else if (en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_m   <= n_m;
            r_m2  <= n_m2;
            r_z   <= n_z;
            r_b1  <= n_b1;
            r_b2  <= n_b2;
            r_q   <= n_q;
            r_d   <= n_d;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_out <= n_out;
        end
    end

    // Hold each item beside the divide and root units, in step with them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lmfsc_pkg::C2_Q; i++) r_da[i].vld <= 1'b0;
            for (int i = 0; i < RW; i++) r_db[i].vld <= 1'b0;
            for (int i = 0; i < MQ; i++) r_dc[i].vld <= 1'b0;
        end else if (en) begin
            r_da[0] <= r_s3;
            for (int i = 1; i < lmfsc_pkg::C2_Q; i++) r_da[i] <= r_da[i-1];
            r_db[0] <= r_da[lmfsc_pkg::C2_Q-1];
            for (int i = 1; i < RW; i++) r_db[i] <= r_db[i-1];
            r_dc[0] <= r_m2;
            for (int i = 1; i < MQ; i++) r_dc[i] <= r_dc[i-1];
        end
    end

    assign o_m_tvalid = r_out.vld;
    assign o_m_tdata  = {{(lmfsc_pkg::OUT_W - lmfsc_pkg::OUT_USED){1'b0}},
                         r_out.pr, r_out.pl,
                         lmfsc_pkg::VEC_W'(r_out.vr), lmfsc_pkg::VEC_W'(r_out.vl)};
    assign o_m_tuser  = {r_out.clmp, r_out.corr};

endmodule
